// File: rtl/iee_pkg.sv
// Shared types, codes and helper functions of the infix expression evaluator.
`timescale 1ns / 1ps

package iee_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;

   // Operator codes as held on the operator stack.
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_LPAR = 3'd4;

   // Status codes of a result.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_PAREN     = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_DIVZERO   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   // Character classes decided by the front end.
   localparam logic [1:0] K_DIGIT = 2'd0;
   localparam logic [1:0] K_LPAR  = 2'd1;
   localparam logic [1:0] K_RPAR  = 2'd2;
   localparam logic [1:0] K_OPER  = 2'd3;

   localparam logic [7:0] CH_ADD  = 8'h2B;
   localparam logic [7:0] CH_SUB  = 8'h2D;
   localparam logic [7:0] CH_MUL  = 8'h2A;
   localparam logic [7:0] CH_DIV  = 8'h2F;
   localparam logic [7:0] CH_LPAR = 8'h28;
   localparam logic [7:0] CH_RPAR = 8'h29;
   localparam logic [8:0] DIGIT_BASE = 9'd48;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] op;
      logic [7:0] symbol;
      logic       last;
   } entry_type;

   function automatic logic [1:0] rank_of(input logic [2:0] code);
      logic [1:0] r;
      if (code == OP_LPAR) begin
         r = 2'd0;
      end else if (code == OP_ADD || code == OP_SUB) begin
         r = 2'd1;
      end else begin
         r = 2'd2;
      end
      return r;
   endfunction

endpackage

// File: rtl/iee_front.sv
// Front end: accepts characters, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module iee_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iee_pkg::req_type  req_data,
   output logic              q_valid,
   output iee_pkg::entry_type q_entry,
   input  logic              q_take
);
   import iee_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   entry_type       classified;
   logic            push, pop;

   always_comb begin
      classified.symbol = req_data.symbol;
      classified.last   = req_data.last;
      classified.op     = OP_ADD;
      priority if (req_data.symbol == CH_LPAR) begin
         classified.kind = K_LPAR;
         classified.op   = OP_LPAR;
      end else if (req_data.symbol == CH_RPAR) begin
         classified.kind = K_RPAR;
      end else if (req_data.symbol == CH_ADD) begin
         classified.kind = K_OPER;
      end else if (req_data.symbol == CH_SUB) begin
         classified.kind = K_OPER;
         classified.op   = OP_SUB;
      end else if (req_data.symbol == CH_MUL) begin
         classified.kind = K_OPER;
         classified.op   = OP_MUL;
      end else if (req_data.symbol == CH_DIV) begin
         classified.kind = K_OPER;
         classified.op   = OP_DIV;
      end else begin
         classified.kind = K_DIGIT;
      end
   end

   assign req_stall = (count_ff == CW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = queue_ff[rd_ptr_ff];
   assign pop       = q_take && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/iee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module iee_div #(
   parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient
);
   import iee_pkg::*;

   localparam int NW = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [NW-1:0]          step_ff, step_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH:0]   trial;
   logic                   fits;

   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[VALUE_WIDTH-1] ? -dividend : dividend;
         den_in  = divisor[VALUE_WIDTH-1] ? -divisor : divisor;
         neg_in  = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
      end else if (busy_ff) begin
         rem_in  = fits ? VALUE_WIDTH'(trial - {1'b0, den_ff}) : trial[VALUE_WIDTH-1:0];
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == NW'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: rtl/iee_back.sv
// Back end: operator and value stacks, the evaluation sequencer and the result register.
`timescale 1ns / 1ps

module iee_back #(
   parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  iee_pkg::entry_type q_entry,
   output logic               q_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output iee_pkg::rsp_type   rsp_data
);
   import iee_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int VW = VALUE_WIDTH;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_RPAR  = 4'd2;
   localparam logic [3:0] S_OPER  = 4'd3;
   localparam logic [3:0] S_OREF  = 4'd4;
   localparam logic [3:0] S_APA   = 4'd5;
   localparam logic [3:0] S_APB   = 4'd6;
   localparam logic [3:0] S_DIVW  = 4'd7;
   localparam logic [3:0] S_POST  = 4'd8;
   localparam logic [3:0] S_DRAIN = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;

   logic [3:0]     state_ff, state_in;
   logic [3:0]     ret_ff, ret_in;
   logic           apply_ff, apply_in;
   logic [2:0]     code_ff, code_in;
   entry_type      cur_ff, cur_in;
   logic [CW-1:0]  ocnt_ff, ocnt_in;
   logic [2:0]     otop_ff, otop_in;
   logic [CW-1:0]  vcnt_ff, vcnt_in;
   logic [VW-1:0]  vtop_ff, vtop_in;
   logic [2:0]     err_ff, err_in;
   logic [31:0]    pdepth_ff, pdepth_in;
   logic           pbroken_ff, pbroken_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic [2:0]     omem [STACK_DEPTH];
   logic [VW-1:0]  vmem [STACK_DEPTH];
   logic [2:0]     ord_ff;
   logic [VW-1:0]  vrd_ff;
   logic           o_we, v_we;
   logic [AW-1:0]  o_waddr, o_raddr, v_waddr, v_raddr;
   logic [2:0]     o_wdata;
   logic [VW-1:0]  v_wdata;

   logic           div_start, div_done;
   logic [VW-1:0]  div_q;
   logic [8:0]     digit_diff;
   logic [VW-1:0]  operand;
   logic [CW-1:0]  cnt_less1, ocnt_less2, vcnt_less2, vcnt_less1;
   logic [2:0]     fin_status;
   logic [63:0]    fin_ext;

   iee_div #(.VALUE_WIDTH(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (vrd_ff),
      .divisor  (vtop_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign digit_diff = {1'b0, cur_ff.symbol} - DIGIT_BASE;
   assign operand    = VW'($signed(digit_diff));
   assign cnt_less1  = ocnt_ff - CW'(1);
   assign ocnt_less2 = ocnt_ff - CW'(2);
   assign vcnt_less1 = vcnt_ff - CW'(1);
   assign vcnt_less2 = vcnt_ff - CW'(2);
   assign fin_status = (err_ff != ST_OK) ? err_ff :
                       ((vcnt_ff != CW'(1)) ? ST_MALFORMED : ST_OK);
   assign fin_ext    = 64'($signed(vtop_ff));

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      apply_in     = apply_ff;
      code_in      = code_ff;
      cur_in       = cur_ff;
      ocnt_in      = ocnt_ff;
      otop_in      = otop_ff;
      vcnt_in      = vcnt_ff;
      vtop_in      = vtop_ff;
      err_in       = err_ff;
      pdepth_in    = pdepth_ff;
      pbroken_in   = pbroken_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_take       = 1'b0;
      o_we         = 1'b0;
      o_waddr      = cnt_less1[AW-1:0];
      o_wdata      = otop_ff;
      o_raddr      = ocnt_less2[AW-1:0];
      v_we         = 1'b0;
      v_waddr      = vcnt_less1[AW-1:0];
      v_wdata      = vtop_ff;
      v_raddr      = vcnt_less2[AW-1:0];
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            q_take = q_valid;
            if (q_valid) begin
               cur_in   = q_entry;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cur_ff.kind == K_LPAR) begin
               if (pdepth_ff != 32'hFFFF_FFFF) begin
                  pdepth_in = pdepth_ff + 32'd1;
               end
            end else if (cur_ff.kind == K_RPAR) begin
               if (pdepth_ff == '0) begin
                  pbroken_in = 1'b1;
               end else begin
                  pdepth_in = pdepth_ff - 32'd1;
               end
            end
            state_in = S_POST;
            code_in  = cur_ff.op;
            if (err_ff == ST_OK) begin
               unique case (cur_ff.kind)
                  K_DIGIT: begin
                     if (vcnt_ff >= CW'(STACK_DEPTH)) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        v_we    = (vcnt_ff != '0);
                        vtop_in = operand;
                        vcnt_in = vcnt_ff + CW'(1);
                     end
                  end
                  K_LPAR: begin
                     if (ocnt_ff >= CW'(STACK_DEPTH)) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        o_we    = (ocnt_ff != '0);
                        otop_in = OP_LPAR;
                        ocnt_in = ocnt_ff + CW'(1);
                     end
                  end
                  K_RPAR: state_in = S_RPAR;
                  default: state_in = S_OPER;
               endcase
            end
         end
         S_RPAR: begin
            if (err_ff != ST_OK) begin
               state_in = S_POST;
            end else if (ocnt_ff == '0) begin
               err_in   = ST_PAREN;
               state_in = S_POST;
            end else begin
               code_in  = otop_ff;
               ocnt_in  = cnt_less1;
               apply_in = (otop_ff != OP_LPAR);
               ret_in   = (otop_ff != OP_LPAR) ? S_RPAR : S_POST;
               state_in = S_OREF;
            end
         end
         S_OPER: begin
            if (err_ff != ST_OK) begin
               state_in = S_POST;
            end else if (ocnt_ff != '0 && rank_of(otop_ff) >= rank_of(cur_ff.op)) begin
               code_in  = otop_ff;
               ocnt_in  = cnt_less1;
               apply_in = 1'b1;
               ret_in   = S_OPER;
               state_in = S_OREF;
            end else begin
               state_in = S_POST;
               if (ocnt_ff >= CW'(STACK_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  o_we    = (ocnt_ff != '0);
                  otop_in = cur_ff.op;
                  ocnt_in = ocnt_ff + CW'(1);
               end
            end
         end
         S_OREF: begin
            otop_in  = ord_ff;
            state_in = apply_ff ? S_APA : ret_ff;
         end
         S_APA: begin
            if (vcnt_ff < CW'(2)) begin
               err_in   = ST_MALFORMED;
               state_in = ret_ff;
            end else begin
               state_in = S_APB;
            end
         end
         S_APB: begin
            state_in = ret_ff;
            unique case (code_ff)
               OP_ADD: begin
                  vtop_in = vrd_ff + vtop_ff;
                  vcnt_in = vcnt_less1;
               end
               OP_SUB: begin
                  vtop_in = vrd_ff - vtop_ff;
                  vcnt_in = vcnt_less1;
               end
               OP_MUL: begin
                  vtop_in = vrd_ff * vtop_ff;
                  vcnt_in = vcnt_less1;
               end
               default: begin
                  if (vtop_ff == '0) begin
                     err_in = ST_DIVZERO;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIVW;
                  end
               end
            endcase
         end
         S_DIVW: begin
            if (div_done) begin
               vtop_in  = div_q;
               vcnt_in  = vcnt_less1;
               state_in = ret_ff;
            end
         end
         S_POST: begin
            if (!cur_ff.last) begin
               state_in = S_IDLE;
            end else if (pbroken_ff || pdepth_ff != '0) begin
               err_in   = ST_PAREN;
               state_in = S_FIN;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (err_ff != ST_OK || ocnt_ff == '0) begin
               state_in = S_FIN;
            end else if (otop_ff == OP_LPAR) begin
               err_in   = ST_PAREN;
               state_in = S_FIN;
            end else begin
               code_in  = otop_ff;
               ocnt_in  = cnt_less1;
               apply_in = 1'b1;
               ret_in   = S_DRAIN;
               state_in = S_OREF;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = fin_status;
               rsp_data_in.value  = (fin_status == ST_OK) ? fin_ext[31:0] : '0;
               ocnt_in            = '0;
               vcnt_in            = '0;
               err_in             = ST_OK;
               pdepth_in          = '0;
               pbroken_in         = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (o_we) begin
         omem[o_waddr] <= o_wdata;
      end
      ord_ff <= omem[o_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[v_waddr] <= v_wdata;
      end
      vrd_ff <= vmem[v_raddr];
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      apply_ff    <= apply_in;
      code_ff     <= code_in;
      cur_ff      <= cur_in;
      otop_ff     <= otop_in;
      vtop_ff     <= vtop_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ocnt_ff      <= '0;
         vcnt_ff      <= '0;
         err_ff       <= ST_OK;
         pdepth_ff    <= '0;
         pbroken_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ocnt_ff      <= ocnt_in;
         vcnt_ff      <= vcnt_in;
         err_ff       <= err_in;
         pdepth_ff    <= pdepth_in;
         pbroken_ff   <= pbroken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/infix_expression_evaluator_unit.sv
// Top level of the infix expression evaluator.
`timescale 1ns / 1ps

// The request channel carries one expression character per transaction
// (symbol, and last to mark the final character). The response channel
// carries one transaction per expression: the value and a status code.
// A front end classifies characters into a four-entry queue, so requests are
// taken while the evaluator is busy or the response register is full.
// The back end evaluates characters one at a time: a digit or an open
// parenthesis passes the take, execute and post states; every operator
// popped from the stack adds a stack read and the apply states, and a
// division also waits for the one-bit-per-cycle divider. The last character
// drains the operator stack likewise before the response is registered.
// Synchronous reset clears the queue, stack counts, error state and the
// response valid flag; stack memories keep stale contents, which are never
// read. While the receiver stalls the response holds, the next final
// character waits, and the queue fills and then stalls requests.

module infix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iee_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iee_pkg::rsp_type rsp_data
);
   import iee_pkg::*;

   // Hand-off between the classifier queue and the evaluator.
   logic      q_valid;
   logic      q_take;
   entry_type q_entry;

   iee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_take    (q_take)
   );

   // The evaluator owns both stacks and the response register.
   iee_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/iee_checker.sv
// Port-level checker for the evaluator and its bind to the top level.
`timescale 1ns / 1ps

module iee_props (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input iee_pkg::rsp_type rsp_data
);
   import iee_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.value == '0)
      else $error("failed expression carries a nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_OVERFLOW)
      else $error("status code out of range");

endmodule

bind infix_expression_evaluator_unit iee_props u_iee_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
